[sv/rgb_to_yuv420_planar_defines.svh]
// ----------------------------------------------------------------------------
// rgb_to_yuv420_planar_defines
// Assertion macros shared by the converter's checker.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_YUV420_PLANAR_DEFINES_SVH
`define RGB_TO_YUV420_PLANAR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RYP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define RYP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/ryp_pkg.sv]
// ----------------------------------------------------------------------------
// ryp_pkg
// Types, constants and helpers of the RGB to planar YUV 4:2:0 converter.
// ----------------------------------------------------------------------------
package ryp_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);

	localparam int REG_W     = 12;
	localparam int CNT_W     = 11;
	localparam int SZ_W      = CNT_W + 2;
	localparam int SMP_W     = 8;
	localparam int PIX_W     = 3 * SMP_W;
	localparam int SUM_W     = SMP_W + 1;
	localparam int TOT_W     = SMP_W + 2;
	localparam int LINE_W    = 3 * SUM_W;
	localparam int LUMA_AW   = 22;
	localparam int CHROMA_AW = 20;
	localparam int YACC_W    = 2 * SMP_W;

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// luma weights, 8 fractional bits
	localparam int Y_WR  = 77;
	localparam int Y_WG  = 150;
	localparam int Y_WB  = 29;
	localparam int Y_RND = 128;

	// chroma weights on 2x2 sums, 10 fractional bits
	localparam int C_SHIFT  = 10;
	localparam int C_BIAS   = (128 << C_SHIFT) + 511;
	localparam int CACC_W   = C_SHIFT + SMP_W + 1;
	localparam int CB_WR    = 43;
	localparam int CB_WG    = 85;
	localparam int CB_WB    = 128;
	localparam int CR_WR    = 128;
	localparam int CR_WG    = 107;
	localparam int CR_WB    = 21;

	localparam logic [1:0] PLANE_Y  = 2'd0;
	localparam logic [1:0] PLANE_CB = 2'd1;
	localparam logic [1:0] PLANE_CR = 2'd2;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_GRAY   = 2'd2;

	localparam logic [REG_W-1:0] WIDTH_RST  = REG_W'(MAX_WIDTH);
	localparam logic [REG_W-1:0] HEIGHT_RST = REG_W'(MAX_HEIGHT);
	localparam logic [SZ_W-1:0]  WIDTH_LIM  = SZ_W'((MAX_WIDTH / 2) * 2);
	localparam logic [SZ_W-1:0]  HEIGHT_LIM = SZ_W'((MAX_HEIGHT / 2) * 2);

	typedef struct packed {
		logic [REG_W-1:0] image_width;
		logic [REG_W-1:0] image_height;
		logic             gray_input;
	} cfg_t;

	typedef struct packed {
		logic [LUMA_AW-1:0]   luma_addr;
		logic [CHROMA_AW-1:0] chroma_addr;
		logic [SMP_W-1:0]     y;
		logic [SMP_W-1:0]     cb;
		logic [SMP_W-1:0]     cr;
		logic                 chroma;
		logic                 eof;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} q_xfer_t;

	// even size, at least 2, at most the even limit
	function automatic logic [SZ_W-1:0] effective_size(input logic [REG_W-1:0] raw,
			input logic [SZ_W-1:0] lim);
		logic [SZ_W-1:0] e;
		e = SZ_W'({raw[REG_W-1:1], 1'b0});
		if (e < SZ_W'(2)) e = SZ_W'(2);
		if (e > lim) e = lim;
		return e;
	endfunction

endpackage

[sv/ryp_ifs.sv]
// ----------------------------------------------------------------------------
// ryp_ifs
// Valid/ready channels of the converter: RGB pixels in, plane samples out.
// ----------------------------------------------------------------------------
interface ryp_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_channel;
	logic [7:0] green_channel;
	logic [7:0] blue_channel;

	modport source (output valid, output first_channel, output green_channel,
		output blue_channel, input ready);
	modport sink (input valid, input first_channel, input green_channel,
		input blue_channel, output ready);
endinterface

interface ryp_sample_if;
	logic        valid;
	logic        ready;
	logic [1:0]  plane;
	logic [21:0] sample_address;
	logic [7:0]  sample_value;
	logic        last_of_item;
	logic        end_of_frame;

	modport source (output valid, output plane, output sample_address,
		output sample_value, output last_of_item, output end_of_frame, input ready);
	modport sink (input valid, input plane, input sample_address,
		input sample_value, input last_of_item, input end_of_frame, output ready);
endinterface

[sv/ryp_ram.sv]
// ----------------------------------------------------------------------------
// ryp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ryp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/ryp_front.sv]
// ----------------------------------------------------------------------------
// ryp_front
// Accepts pixels, tracks raster position, computes luma, keeps the pair-sum
// line store and forms Cb/Cr over two pipeline stages.
// ----------------------------------------------------------------------------
module ryp_front import ryp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	ryp_pixel_if.sink         pixel,
	input  logic [QCNT_W-1:0] q_level,
	output q_xfer_t           q_wr
);

	logic                 fire;
	logic [SMP_W-1:0]     r, g, b;
	logic [SZ_W-1:0]      w_eff, h_eff;
	logic                 odd_col, odd_row, end_row, end_frame, chroma_px;
	logic [SUM_W-1:0]     ps_r, ps_g, ps_b;
	logic [YACC_W-1:0]    y_acc;
	logic [QCNT_W:0]      occ;
	logic [LINE_AW-1:0]   line_idx;
	logic [LINE_W-1:0]    line_rdata;

	logic [CNT_W-1:0]     col_q, row_q;
	logic [PIX_W-1:0]     left_q;
	logic [LUMA_AW-1:0]   luma_addr_q;
	logic [CHROMA_AW-1:0] chroma_addr_q;

	logic                 v_s1, chroma_s1, eof_s1;
	logic [SMP_W-1:0]     y_s1;
	logic [LUMA_AW-1:0]   luma_addr_s1;
	logic [CHROMA_AW-1:0] chroma_addr_s1;
	logic [LINE_W-1:0]    ps_s1;

	logic                 v_s2, chroma_s2, eof_s2;
	logic [SMP_W-1:0]     y_s2;
	logic [LUMA_AW-1:0]   luma_addr_s2;
	logic [CHROMA_AW-1:0] chroma_addr_s2;
	logic [TOT_W-1:0]     sr_s2, sg_s2, sb_s2;

	logic [CACC_W-1:0]    cb_acc, cr_acc;

	// accept only while the queue has room for everything in flight
	assign occ = {1'b0, q_level} + (QCNT_W + 1)'(v_s1) + (QCNT_W + 1)'(v_s2);
	assign pixel.ready = occ < (QCNT_W + 1)'(QDEPTH);
	assign fire = pixel.valid & pixel.ready;

	assign r = pixel.first_channel;
	assign g = cfg.gray_input ? pixel.first_channel : pixel.green_channel;
	assign b = cfg.gray_input ? pixel.first_channel : pixel.blue_channel;

	assign w_eff = effective_size(cfg.image_width, WIDTH_LIM);
	assign h_eff = effective_size(cfg.image_height, HEIGHT_LIM);

	assign odd_col   = col_q[0];
	assign odd_row   = row_q[0];
	assign end_row   = ({2'b00, col_q} + SZ_W'(1)) >= w_eff;
	assign end_frame = end_row && (({2'b00, row_q} + SZ_W'(1)) >= h_eff);
	assign chroma_px = odd_col & odd_row;
	assign line_idx  = col_q[LINE_AW:1];

	assign ps_r = SUM_W'(left_q[2*SMP_W +: SMP_W]) + SUM_W'(r);
	assign ps_g = SUM_W'(left_q[SMP_W +: SMP_W]) + SUM_W'(g);
	assign ps_b = SUM_W'(left_q[0 +: SMP_W]) + SUM_W'(b);

	assign y_acc = YACC_W'(Y_WR * int'(r) + Y_WG * int'(g) + Y_WB * int'(b) + Y_RND);

	ryp_ram #(
		.WIDTH(LINE_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (fire & odd_col & ~odd_row),
		.waddr (line_idx),
		.wdata ({ps_r, ps_g, ps_b}),
		.re    (fire & chroma_px),
		.raddr (line_idx),
		.rdata (line_rdata)
	);

	// raster position and plane addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			left_q        <= '0;
			luma_addr_q   <= '0;
			chroma_addr_q <= '0;
		end else if (fire) begin
			if (!odd_col) begin
				left_q <= {r, g, b};
			end
			if (end_row) begin
				col_q <= '0;
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
			if (end_frame) begin
				row_q         <= '0;
				luma_addr_q   <= '0;
				chroma_addr_q <= '0;
			end else begin
				if (end_row) begin
					row_q <= row_q + CNT_W'(1);
				end
				luma_addr_q <= luma_addr_q + LUMA_AW'(1);
				if (chroma_px) begin
					chroma_addr_q <= chroma_addr_q + CHROMA_AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= fire;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			chroma_s1      <= chroma_px;
			eof_s1         <= end_frame;
			y_s1           <= y_acc[YACC_W-1 -: SMP_W];
			luma_addr_s1   <= luma_addr_q;
			chroma_addr_s1 <= chroma_addr_q;
			ps_s1          <= {ps_r, ps_g, ps_b};
		end
		if (v_s1) begin
			chroma_s2      <= chroma_s1;
			eof_s2         <= eof_s1;
			y_s2           <= y_s1;
			luma_addr_s2   <= luma_addr_s1;
			chroma_addr_s2 <= chroma_addr_s1;
			// add the pair sums of the even row above
			sr_s2 <= TOT_W'(ps_s1[2*SUM_W +: SUM_W]) + TOT_W'(line_rdata[2*SUM_W +: SUM_W]);
			sg_s2 <= TOT_W'(ps_s1[SUM_W +: SUM_W]) + TOT_W'(line_rdata[SUM_W +: SUM_W]);
			sb_s2 <= TOT_W'(ps_s1[0 +: SUM_W]) + TOT_W'(line_rdata[0 +: SUM_W]);
		end
	end

	// bias keeps both sums non-negative, so the shift is a floor
	assign cb_acc = CACC_W'(C_BIAS + CB_WB * int'(sb_s2) - CB_WR * int'(sr_s2)
		- CB_WG * int'(sg_s2));
	assign cr_acc = CACC_W'(C_BIAS + CR_WR * int'(sr_s2) - CR_WG * int'(sg_s2)
		- CR_WB * int'(sb_s2));

	always_comb begin
		q_wr.valid             = v_s2;
		q_wr.entry.luma_addr   = luma_addr_s2;
		q_wr.entry.chroma_addr = chroma_addr_s2;
		q_wr.entry.y           = y_s2;
		q_wr.entry.cb          = cb_acc[CACC_W-1] ? '1 : cb_acc[C_SHIFT +: SMP_W];
		q_wr.entry.cr          = cr_acc[CACC_W-1] ? '1 : cr_acc[C_SHIFT +: SMP_W];
		q_wr.entry.chroma      = chroma_s2;
		q_wr.entry.eof         = eof_s2;
	end

endmodule

[sv/ryp_queue.sv]
// ----------------------------------------------------------------------------
// ryp_queue
// Small FIFO of converted pixels between the front and the output sequencer.
// ----------------------------------------------------------------------------
module ryp_queue import ryp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  q_xfer_t           wr,
	input  logic              pop,
	output q_xfer_t           rd,
	output logic [QCNT_W-1:0] level
);

	entry_t              slots [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign do_pop   = pop & (count_q != '0);
	assign rd.valid = count_q != '0;
	assign rd.entry = slots[rd_ptr_q];
	assign level    = count_q;

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			slots[wr_ptr_q] <= wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(wr.valid) - QCNT_W'(do_pop);
		end
	end

endmodule

[sv/ryp_back.sv]
// ----------------------------------------------------------------------------
// ryp_back
// Output sequencer: turns each queued pixel into a Y beat, or Y, Cb, Cr beats.
// ----------------------------------------------------------------------------
module ryp_back import ryp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_xfer_t     rd,
	output logic        pop,
	ryp_sample_if.source sample
);

	entry_t     cur_q;
	logic       busy_q;
	logic [1:0] phase_q;
	logic [1:0] phase_nxt;
	logic       fire, last_beat;

	assign fire      = sample.valid & sample.ready;
	assign last_beat = (phase_q == PLANE_CR) || ((phase_q == PLANE_Y) && !cur_q.chroma);
	assign pop       = rd.valid && (!busy_q || (fire && last_beat));

	always_comb begin
		unique case (phase_q)
			PLANE_Y:  phase_nxt = PLANE_CB;
			PLANE_CB: phase_nxt = PLANE_CR;
			default:  phase_nxt = PLANE_Y;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PLANE_Y;
		end else if (pop) begin
			busy_q  <= 1'b1;
			phase_q <= PLANE_Y;
		end else if (fire && last_beat) begin
			busy_q  <= 1'b0;
			phase_q <= PLANE_Y;
		end else if (fire) begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= rd.entry;
		end
	end

	always_comb begin
		sample.valid        = busy_q;
		sample.plane        = phase_q;
		sample.last_of_item = last_beat;
		sample.end_of_frame = last_beat & cur_q.eof;
		unique case (phase_q)
			PLANE_Y: begin
				sample.sample_address = cur_q.luma_addr;
				sample.sample_value   = cur_q.y;
			end
			PLANE_CB: begin
				sample.sample_address = LUMA_AW'(cur_q.chroma_addr);
				sample.sample_value   = cur_q.cb;
			end
			default: begin
				sample.sample_address = LUMA_AW'(cur_q.chroma_addr);
				sample.sample_value   = cur_q.cr;
			end
		endcase
	end

endmodule

[sv/rgb_to_yuv420_planar.sv]
// ----------------------------------------------------------------------------
// rgb_to_yuv420_planar
// RGB raster pixels to planar YUV 4:2:0 samples, BT.601 8-bit fixed point.
//
//   channel  kind        beat
//   -------  ----------  ------------------------------------------------
//   pixel    valid/ready one RGB pixel (or gray in first_channel)
//   sample   valid/ready one plane sample with its address and flags
//   apb      psel/penab  image_width @0x0, image_height @0x4, gray_input @0x8
//
// A pixel can be taken every cycle while the queue has room. The sample
// port moves one beat per cycle while ready is high, so a pixel at an odd
// column of an odd row holds it for its Y, Cb and Cr beats; over a frame the
// pixel rate is set by this port. An 8-entry queue decouples the two sides;
// the pixel port stalls only when the queue and the 2-stage front fill up.
// Reset clears position and queue; the line store needs no clearing.
// ----------------------------------------------------------------------------
module rgb_to_yuv420_planar import ryp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	ryp_pixel_if.sink          pixel,
	ryp_sample_if.source       sample
);

	cfg_t              cfg_q;
	logic [1:0]        reg_idx;
	logic              wr_en;
	q_xfer_t           q_wr, q_rd;
	logic              q_pop;
	logic [QCNT_W-1:0] q_level;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= WIDTH_RST;
			cfg_q.image_height <= HEIGHT_RST;
			cfg_q.gray_input   <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WIDTH:  cfg_q.image_width  <= pwdata[REG_W-1:0];
				REG_HEIGHT: cfg_q.image_height <= pwdata[REG_W-1:0];
				REG_GRAY:   cfg_q.gray_input   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_WIDTH:  prdata = PDATA_W'(cfg_q.image_width);
			REG_HEIGHT: prdata = PDATA_W'(cfg_q.image_height);
			REG_GRAY:   prdata = PDATA_W'(cfg_q.gray_input);
			default:    prdata = '0;
		endcase
	end

	ryp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.pixel   (pixel),
		.q_level (q_level),
		.q_wr    (q_wr)
	);

	ryp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.pop    (q_pop),
		.rd     (q_rd),
		.level  (q_level)
	);

	ryp_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (q_rd),
		.pop    (q_pop),
		.sample (sample)
	);

endmodule

[sv/ryp_checker.sv]
// ----------------------------------------------------------------------------
// ryp_checker
// Port-level checks on the sample channel of the converter.
// ----------------------------------------------------------------------------
`include "rgb_to_yuv420_planar_defines.svh"

module ryp_checker import ryp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               valid,
	input logic               ready,
	input logic [1:0]         plane,
	input logic [LUMA_AW-1:0] sample_address,
	input logic [SMP_W-1:0]   sample_value,
	input logic               last_of_item,
	input logic               end_of_frame
);

	// a luma beat that does not close its pixel is followed by Cb
	`RYP_ASSERT_NEXT(a_y_then_cb, clk, arst_n, valid && ready && plane == PLANE_Y && !last_of_item, valid && plane == PLANE_CB, "luma beat without last not followed by Cb")
	// Cb is followed at once by Cr of the same block
	`RYP_ASSERT_NEXT(a_cb_then_cr, clk, arst_n, valid && ready && plane == PLANE_CB, valid && plane == PLANE_CR && $stable(sample_address), "Cb beat not followed by Cr")
	// frame end only on the closing beat of a pixel
	`RYP_ASSERT_NOW(a_eof_last, clk, arst_n, valid && end_of_frame, last_of_item && plane != PLANE_CB, "end_of_frame on a beat that does not close its pixel")
	// hold a stalled beat
	`RYP_ASSERT_NEXT(a_hold, clk, arst_n, valid && !ready, valid && $stable(plane) && $stable(sample_value) && $stable(sample_address), "stalled beat changed")

endmodule

bind rgb_to_yuv420_planar ryp_checker u_ryp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.valid          (sample.valid),
	.ready          (sample.ready),
	.plane          (sample.plane),
	.sample_address (sample.sample_address),
	.sample_value   (sample.sample_value),
	.last_of_item   (sample.last_of_item),
	.end_of_frame   (sample.end_of_frame)
);
